// File: sv/ssip_pkg.sv
// Shared types and constants for the sorted stack insert/pop block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ssip_pkg;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int VAL_W       = 32;
    localparam int LIMIT_W     = 5;
    localparam int COUNT_OUT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_POP    = 1'b1
    } action_t;

    typedef struct packed {
        logic             ins;
        logic [VAL_W-1:0] value;
    } cell_ctl_t;

    typedef struct packed {
        logic in_use;
        logic at_end;
    } cell_pos_t;

endpackage

// File: sv/ssip_cell.sv
// One slot of the sorted chain: holds a value, compares it with the incoming
// value and takes either its lower neighbor's value or the new value.
// Depends on ssip_pkg.
`timescale 1ns / 1ps

module ssip_cell
    import ssip_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  cell_pos_t        pos,
    input  logic             prev_lt,
    input  logic [VAL_W-1:0] prev_value,
    output logic             lt,
    output logic [VAL_W-1:0] value
);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    // new value sorts strictly below this occupied slot
    assign lt    = pos.in_use && ($signed(ctl.value) < $signed(value_reg));
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.ins)
        begin
            if (prev_lt)
            begin
                value_next = prev_value;
            end
            else if (lt || pos.at_end)
            begin
                value_next = ctl.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: sv/sorted_stack_insert_pop.sv
// Top level of the sorted stack priority queue: cell chain, count, limit
// register and result registers. Depends on ssip_pkg and ssip_cell.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. action selects insert of value or pop of the largest entry.
//   Each transaction yields one result, shown for exactly one cycle with done
//   high: status, popped_value, top_value and entry_count after the step.
//   The receiver cannot stall; results are never held back.
//   The accepting edge loads the pending registers, which then load the result
//   registers and done. busy is high for the cycle after accept, so a new
//   transaction waits until the pending step is done; that step reads the
//   new top out of the chain by the updated count.
//   Inserts are a parallel compare and shift along the row of DEPTH cells in
//   the accepting cycle; pops only move the count.
//   Config channel: cfg_data is the entry limit, written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write it only while idle.
//   Reset: count 0, limit 16, no result pending. Stored values are not
//   cleared; only slots below the count are ever read.
`timescale 1ns / 1ps

module sorted_stack_insert_pop
    import ssip_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   action,
    input  logic [VAL_W-1:0]       value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LIMIT_W-1:0]     cfg_data,
    output logic                   done,
    output logic [1:0]             status,
    output logic [VAL_W-1:0]       popped_value,
    output logic [VAL_W-1:0]       top_value,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [LIMIT_W-1:0]     limit_reg, limit_next;
    logic                   pending_reg, pending_next;
    status_t                pend_status_reg, pend_status_next;
    logic [VAL_W-1:0]       pend_popped_reg, pend_popped_next;
    logic                   done_reg, done_next;
    status_t                status_reg, status_next;
    logic [VAL_W-1:0]       popped_reg, popped_next;
    logic [VAL_W-1:0]       top_reg, top_next;
    logic [COUNT_OUT_W-1:0] count_out_reg, count_out_next;

    logic             accept;
    logic             full;
    logic             empty;
    cell_ctl_t        ctl;
    logic             cell_lt  [DEPTH];
    logic [VAL_W-1:0] cell_val [DEPTH];
    logic [IDX_W-1:0] top_idx;
    logic [VAL_W-1:0] top_sel;

    assign accept    = start && !busy;
    assign busy      = pending_reg;
    assign cfg_ready = 1'b1;
    assign full      = (32'(count_reg) >= 32'(limit_reg)) || (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    assign ctl.ins   = accept && (action_t'(action) == ACT_INSERT) && !full;
    assign ctl.value = value;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_pos_t cpos;
            assign cpos.in_use = (CNT_W'(gi) < count_reg);
            assign cpos.at_end = (CNT_W'(gi) == count_reg);
            if (gi == 0)
            begin : g_first
                ssip_cell u_cell (
                    .clk        (clk),
                    .ctl        (ctl),
                    .pos        (cpos),
                    .prev_lt    (1'b0),
                    .prev_value ('0),
                    .lt         (cell_lt[gi]),
                    .value      (cell_val[gi])
                );
            end
            else
            begin : g_rest
                ssip_cell u_cell (
                    .clk        (clk),
                    .ctl        (ctl),
                    .pos        (cpos),
                    .prev_lt    (cell_lt[gi-1]),
                    .prev_value (cell_val[gi-1]),
                    .lt         (cell_lt[gi]),
                    .value      (cell_val[gi])
                );
            end
        end
    endgenerate

    assign top_idx = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        top_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (top_idx == IDX_W'(i))
            begin
                top_sel = top_sel | cell_val[i];
            end
        end
    end

    always_comb
    begin
        count_next       = count_reg;
        limit_next       = limit_reg;
        pending_next     = pending_reg;
        pend_status_next = pend_status_reg;
        pend_popped_next = pend_popped_reg;
        done_next        = pending_reg;
        status_next      = status_reg;
        popped_next      = popped_reg;
        top_next         = top_reg;
        count_out_next   = count_out_reg;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        if (accept)
        begin
            pending_next     = 1'b1;
            pend_popped_next = '0;
            pend_status_next = ST_DONE;
            case (action_t'(action))
                ACT_INSERT:
                begin
                    if (full)
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    if (empty)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next       = count_reg - CNT_W'(1);
                        pend_popped_next = top_reg;
                    end
                end
            endcase
        end

        if (pending_reg)
        begin
            pending_next   = 1'b0;
            status_next    = pend_status_reg;
            popped_next    = pend_popped_reg;
            top_next       = empty ? '0 : top_sel;
            count_out_next = COUNT_OUT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            limit_reg       <= LIMIT_RESET;
            pending_reg     <= 1'b0;
            pend_status_reg <= ST_DONE;
            pend_popped_reg <= '0;
            done_reg        <= 1'b0;
            status_reg      <= ST_DONE;
            popped_reg      <= '0;
            top_reg         <= '0;
            count_out_reg   <= '0;
        end
        else
        begin
            count_reg       <= count_next;
            limit_reg       <= limit_next;
            pending_reg     <= pending_next;
            pend_status_reg <= pend_status_next;
            pend_popped_reg <= pend_popped_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            popped_reg      <= popped_next;
            top_reg         <= top_next;
            count_out_reg   <= count_out_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign top_value    = top_reg;
    assign entry_count  = count_out_reg;

endmodule

// File: sv/ssip_chk.sv
// Port-level checker for sorted_stack_insert_pop, bound to the top level.
// Depends on ssip_pkg.
`timescale 1ns / 1ps

module ssip_chk
    import ssip_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input logic [1:0]             status,
    input logic [VAL_W-1:0]       popped_value,
    input logic [VAL_W-1:0]       top_value,
    input logic [COUNT_OUT_W-1:0] entry_count
);

    // every result comes from an accepted transaction, through the pending registers
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without transaction");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("busy/done wrong after transaction");

    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL || status == ST_EMPTY)) |-> (popped_value == '0))
        else $error("refused transaction returned a value");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (entry_count == '0 && top_value == '0))
        else $error("empty pop with entries");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(entry_count) <= DEPTH)
                 && (status == ST_DONE || status == ST_FULL || status == ST_EMPTY))
        else $error("count or status out of range");

endmodule

bind sorted_stack_insert_pop ssip_chk u_ssip_chk (.*);
